FILE: sv/i2dec_pkg.sv
// Shared constants, types and state codes for the signed integer to decimal text core.
// No dependencies; every other file imports this package.
package i2dec_pkg;

  // Width of the converted value (two's complement).
  localparam int VALUE_BITS = 32;
  // Decimal digits of the largest magnitude, 2**(VALUE_BITS-1).
  localparam int DIGITS     = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int BCD_W      = 4 * DIGITS;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int LEFT_W     = $clog2(DIGITS + 1);

  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] MINUS_SIGN = 8'h2D;
  localparam logic [7:0] TERMINATOR = 8'h00;

  typedef enum logic [1:0] {
    EMIT_IDLE,
    EMIT_SIGN,
    EMIT_DIGITS,
    EMIT_TERM
  } emit_state_e;

  // Status from the converter to the character emitter.
  typedef struct packed {
    logic done;
    logic neg;
  } conv_status_t;

endpackage

FILE: sv/signed_int_to_decimal_text_core.sv
// Top level of the signed integer to decimal ASCII text converter.
// Depends on i2dec_pkg, i2dec_dabble and i2dec_emit.
//
//   channel  | ports                                  | flow
//   ---------+----------------------------------------+-------------------------------
//   request  | start_i, busy_o, value_i               | taken when start_i & !busy_o
//   result   | result_valid_o, character_o,           | registered characters,
//            | last_char_o                            | no back-pressure
//
// Sequence: a request passes through the shift-and-add-3 converter (one magnitude bit
// per cycle), a handover to the emitter, then a minus sign if negative, one step per
// BCD digit slot (DIGITS) and the terminator. The bit-serial converter and the digit
// shifter set the pace; one request is in flight at a time.
// Reset: asynchronous, active low; clears all control state, no clearing pass.
// Stalls: the receiver cannot stall; busy_o holds off new requests until the
// terminator has left the emitter.
module signed_int_to_decimal_text_core
  import i2dec_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  result_valid_o,
  output logic [7:0]            character_o,
  output logic                  last_char_o
);

  logic             conv_busy;
  logic             emit_busy;
  logic             accept;
  conv_status_t     conv_stat;
  logic [BCD_W-1:0] bcd;

  // Accept a request only when both the converter and the emitter are free.
  assign accept = start_i & ~busy_o;
  assign busy_o = conv_busy | emit_busy;

  // Convert the magnitude to packed BCD, one bit per cycle.
  i2dec_dabble u_dabble (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .value_i  (value_i),
    .busy_o   (conv_busy),
    .status_o (conv_stat),
    .bcd_o    (bcd)
  );

  // Walk the digits out most significant first, dropping leading zeros.
  i2dec_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (conv_stat),
    .bcd_i    (bcd),
    .busy_o   (emit_busy),
    .valid_o  (result_valid_o),
    .char_o   (character_o),
    .last_o   (last_char_o)
  );

  // The terminator is always a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_char_o |-> character_o == TERMINATOR)
    else $error("terminator result carries a nonzero byte");

  // Every other character is a minus sign or a decimal digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_char_o |->
      (character_o == MINUS_SIGN) ||
      (character_o >= DIGIT_ZERO && character_o <= DIGIT_ZERO + 8'd9))
    else $error("non-terminator result is not a sign or digit");

  // An accepted request keeps the core busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("core not busy after accepting a request");

  // The converter hands over only to an idle emitter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_stat.done |-> !emit_busy)
    else $error("conversion finished while emitter still busy");

endmodule

FILE: sv/i2dec_dabble.sv
// Bit-serial binary to BCD converter (shift and add-3), one magnitude bit per cycle.
// Depends on i2dec_pkg.
module i2dec_dabble
  import i2dec_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  busy_o,
  output conv_status_t          status_o,
  output logic [BCD_W-1:0]      bcd_o
);

  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic                  neg_q, neg_d;
  logic [BCD_W-1:0]      adj;
  logic [VALUE_BITS-1:0] mag;

  // Add 3 to every digit of 5 or more before the shift.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
    end
  end

  assign mag = value_i[VALUE_BITS-1] ? (~value_i) + VALUE_BITS'(1) : value_i;

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (load_i) begin
      bin_d  = mag;
      bcd_d  = '0;
      cnt_d  = CNT_W'(VALUE_BITS);
      busy_d = 1'b1;
      neg_d  = value_i[VALUE_BITS-1];
    end else if (busy_q) begin
      bcd_d = {adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
      bin_d = bin_q << 1;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  assign busy_o        = busy_q | done_q;
  assign status_o.done = done_q;
  assign status_o.neg  = neg_q;
  assign bcd_o         = bcd_q;

endmodule

FILE: sv/i2dec_emit.sv
// Character emitter: minus sign if negative, digits without leading zeros, then the terminator.
// Depends on i2dec_pkg; fed by i2dec_dabble.
module i2dec_emit
  import i2dec_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  conv_status_t     status_i,
  input  logic [BCD_W-1:0] bcd_i,
  output logic             busy_o,
  output logic             valid_o,
  output logic [7:0]       char_o,
  output logic             last_o
);

  emit_state_e       state_q, state_d;
  logic [BCD_W-1:0]  sh_q, sh_d;
  logic [LEFT_W-1:0] left_q, left_d;
  logic              started_q, started_d;
  logic              valid_q, valid_d;
  logic [7:0]        char_q, char_d;
  logic              last_q, last_d;
  logic [3:0]        top;

  assign top = sh_q[BCD_W-1 -: 4];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      EMIT_IDLE: begin
        if (status_i.done) begin
          state_d = status_i.neg ? EMIT_SIGN : EMIT_DIGITS;
        end
      end
      EMIT_SIGN:   state_d = EMIT_DIGITS;
      EMIT_DIGITS: begin
        if (left_q == LEFT_W'(1)) begin
          state_d = EMIT_TERM;
        end
      end
      EMIT_TERM:   state_d = EMIT_IDLE;
      default:     state_d = EMIT_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    sh_d      = sh_q;
    left_d    = left_q;
    started_d = started_q;
    valid_d   = 1'b0;
    char_d    = char_q;
    last_d    = 1'b0;
    case (state_q)
      EMIT_IDLE: begin
        if (status_i.done) begin
          sh_d      = bcd_i;
          left_d    = LEFT_W'(DIGITS);
          started_d = 1'b0;
        end
      end
      EMIT_SIGN: begin
        valid_d = 1'b1;
        char_d  = MINUS_SIGN;
      end
      EMIT_DIGITS: begin
        // Drop leading zeros, but always keep the final digit.
        if (top != 4'd0 || started_q || left_q == LEFT_W'(1)) begin
          valid_d   = 1'b1;
          char_d    = DIGIT_ZERO + {4'h0, top};
          started_d = 1'b1;
        end
        sh_d   = sh_q << 4;
        left_d = left_q - LEFT_W'(1);
      end
      EMIT_TERM: begin
        valid_d = 1'b1;
        char_d  = TERMINATOR;
        last_d  = 1'b1;
      end
      default: begin
        valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= EMIT_IDLE;
      valid_q   <= 1'b0;
      last_q    <= 1'b0;
      started_q <= 1'b0;
      left_q    <= '0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      last_q    <= last_d;
      started_q <= started_d;
      left_q    <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    char_q <= char_d;
  end

  assign busy_o  = (state_q != EMIT_IDLE);
  assign valid_o = valid_q;
  assign char_o  = char_q;
  assign last_o  = last_q & valid_q;

endmodule
